// ----- sv/mrrx_pkg.sv -----
// Package for the Modbus RTU response receiver.
// Holds the shared constants, status and register codes, and the CRC unit control struct.
// No dependencies.
package mrrx_pkg;

	localparam int BUF_BYTES_DEF = 256;
	localparam int MAX_REGS_DEF  = 32;
	localparam int RESULT_CAP    = 32;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 2'd1;
	localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
	localparam logic [7:0] GAP_LIMIT_RST  = 8'd4;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [2:0] ST_WORD       = 3'd0;
	localparam logic [2:0] ST_CRC_ERR    = 3'd1;
	localparam logic [2:0] ST_ADDR_MISS  = 3'd2;
	localparam logic [2:0] ST_OTHER_FUNC = 3'd3;
	localparam logic [2:0] ST_NO_REGS    = 3'd4;

	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  SILENCE_MAX = 8'hFF;

	typedef struct packed {
		logic init;
		logic xor_en;
		logic shift_en;
	} crc_ctl_t;

endpackage

// ----- sv/mrrx_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mrrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/mrrx_crc.sv -----
// CRC-16 Modbus unit that advances one bit per shift command.
// Depends on mrrx_pkg for the polynomial, initial value and control struct.
module mrrx_crc (
	input  logic               clk,
	input  mrrx_pkg::crc_ctl_t ctl,
	input  logic [7:0]         data,
	output logic [15:0]        crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			crc_q <= mrrx_pkg::CRC_INIT;
		end else if (ctl.xor_en) begin
			crc_q <= crc_q ^ {8'h00, data};
		end else if (ctl.shift_en) begin
			if (crc_q[0]) begin
				crc_q <= (crc_q >> 1) ^ mrrx_pkg::CRC_POLY;
			end else begin
				crc_q <= crc_q >> 1;
			end
		end
	end

	assign crc = crc_q;

endmodule

// ----- sv/modbus_rtu_response_receiver_unit.sv -----
// Modbus RTU response receiver. Bytes and ticks are accepted only in the idle state.
// Closing a frame of N bytes runs the bit-serial CRC unit over N-2 bytes (read, fold, shift per
// bit), reads the stored CRC, checks, then reads and outputs each word, high byte first.
// The single CRC unit and the one RAM read port serialize this; input waits meanwhile.
// Reset: slave address 1, gap limit 4, length and silence zero; the buffer is not cleared.
// Depends on mrrx_pkg, mrrx_ram and mrrx_crc.
module modbus_rtu_response_receiver_unit #(
	parameter int BUF_BYTES = mrrx_pkg::BUF_BYTES_DEF,
	parameter int MAX_REGS  = mrrx_pkg::MAX_REGS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [7:0]                     byte_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     frame_status,
	output logic [4:0]                     reg_index,
	output logic [15:0]                    reg_value,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mrrx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	localparam int AW   = $clog2(BUF_BYTES);
	localparam int CW   = (AW > 7) ? AW : 7;
	localparam int WLIM = (MAX_REGS < mrrx_pkg::RESULT_CAP) ? MAX_REGS : mrrx_pkg::RESULT_CAP;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_DATA,
		S_SHIFT,
		S_CHECK,
		S_WRD_HI,
		S_WCAP_HI,
		S_WRD_LO,
		S_WCAP_LO,
		S_OUT
	} state_t;

	state_t state_q;

	logic [AW-1:0] len_q, flen_q, ptr_q;
	logic [7:0]    sil_q, slave_q, gap_q;
	logic [7:0]    hdr_addr_q, hdr_func_q, hdr_cnt_q, crc_lo_q, crc_hi_q, hi_q;
	logic [2:0]    bit_q;
	logic [5:0]    words_q;
	logic [4:0]    wi_q;

	logic          out_valid_q, last_q;
	logic [2:0]    status_q;
	logic [4:0]    idx_q;
	logic [15:0]   value_q;

	logic          in_acc, out_acc, byte_we, close_go;
	logic [7:0]    sil_next;
	logic [AW-1:0] len_m2;
	logic [CW-1:0] half_cnt, avail, words_c;
	logic [5:0]    words_n;
	logic [7:0]    rdata;
	logic [15:0]   crc;
	mrrx_pkg::crc_ctl_t crc_ctl;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;
	assign byte_we   = in_acc && (opcode == mrrx_pkg::OP_BYTE);
	assign len_m2    = flen_q - AW'(2);

	assign sil_next = (sil_q == mrrx_pkg::SILENCE_MAX) ? sil_q : sil_q + 8'd1;
	assign close_go = in_acc && (opcode == mrrx_pkg::OP_TICK) && (sil_next > gap_q) &&
		(len_q != '0);

	// Word count limited by the byte count, the bytes before the CRC and the result cap.
	always_comb begin
		half_cnt = CW'(hdr_cnt_q[7:1]);
		avail    = (flen_q >= AW'(5)) ? CW'((flen_q - AW'(5)) >> 1) : '0;
		words_c  = (half_cnt < avail) ? half_cnt : avail;
		if (words_c > CW'(WLIM)) begin
			words_c = CW'(WLIM);
		end
		words_n = 6'(words_c);
	end

	always_comb begin
		crc_ctl          = '0;
		crc_ctl.init     = close_go;
		crc_ctl.xor_en   = (state_q == S_DATA) && (ptr_q < len_m2);
		crc_ctl.shift_en = (state_q == S_SHIFT);
	end

	mrrx_ram #(
		.WIDTH (8),
		.DEPTH (BUF_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (byte_we),
		.waddr (len_q),
		.wdata (byte_value),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	mrrx_crc u_crc (
		.clk  (clk),
		.ctl  (crc_ctl),
		.data (rdata),
		.crc  (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			flen_q      <= '0;
			ptr_q       <= '0;
			sil_q       <= '0;
			slave_q     <= mrrx_pkg::SLAVE_ADDR_RST;
			gap_q       <= mrrx_pkg::GAP_LIMIT_RST;
			hdr_addr_q  <= '0;
			hdr_func_q  <= '0;
			hdr_cnt_q   <= '0;
			crc_lo_q    <= '0;
			crc_hi_q    <= '0;
			hi_q        <= '0;
			bit_q       <= '0;
			words_q     <= '0;
			wi_q        <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			status_q    <= mrrx_pkg::ST_WORD;
			idx_q       <= '0;
			value_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mrrx_pkg::CFG_SLAVE_ADDR: slave_q <= cfg_data;
					mrrx_pkg::CFG_GAP_LIMIT:  gap_q   <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (byte_we) begin
						sil_q <= '0;
						if (({1'b0, len_q} + (AW+1)'(1)) == (AW+1)'(BUF_BYTES)) begin
							len_q <= '0;
						end else begin
							len_q <= len_q + AW'(1);
						end
					end else if (in_acc) begin
						sil_q <= sil_next;
						if (close_go) begin
							flen_q <= len_q;
							len_q  <= '0;
							ptr_q  <= '0;
							if (len_q < AW'(4)) begin
								status_q    <= mrrx_pkg::ST_CRC_ERR;
								idx_q       <= '0;
								value_q     <= '0;
								last_q      <= 1'b1;
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (ptr_q < len_m2) begin
						if (ptr_q == AW'(0)) begin
							hdr_addr_q <= rdata;
						end
						if (ptr_q == AW'(1)) begin
							hdr_func_q <= rdata;
						end
						if (ptr_q == AW'(2)) begin
							hdr_cnt_q <= rdata;
						end
						bit_q   <= '0;
						state_q <= S_SHIFT;
					end else if (ptr_q == len_m2) begin
						crc_lo_q <= rdata;
						ptr_q    <= ptr_q + AW'(1);
						state_q  <= S_RD;
					end else begin
						crc_hi_q <= rdata;
						state_q  <= S_CHECK;
					end
				end
				S_SHIFT: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						ptr_q   <= ptr_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_CHECK: begin
					idx_q   <= '0;
					value_q <= '0;
					last_q  <= 1'b1;
					if (crc != {crc_hi_q, crc_lo_q}) begin
						status_q    <= mrrx_pkg::ST_CRC_ERR;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (hdr_addr_q != slave_q) begin
						status_q    <= mrrx_pkg::ST_ADDR_MISS;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (hdr_func_q != mrrx_pkg::FUNC_READ_HOLDING) begin
						status_q    <= mrrx_pkg::ST_OTHER_FUNC;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (words_n == '0) begin
						status_q    <= mrrx_pkg::ST_NO_REGS;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						words_q <= words_n;
						wi_q    <= '0;
						ptr_q   <= AW'(3);
						state_q <= S_WRD_HI;
					end
				end
				S_WRD_HI: begin
					state_q <= S_WCAP_HI;
				end
				S_WCAP_HI: begin
					hi_q    <= rdata;
					ptr_q   <= ptr_q + AW'(1);
					state_q <= S_WRD_LO;
				end
				S_WRD_LO: begin
					state_q <= S_WCAP_LO;
				end
				S_WCAP_LO: begin
					status_q    <= mrrx_pkg::ST_WORD;
					idx_q       <= wi_q;
					value_q     <= {hi_q, rdata};
					last_q      <= (({1'b0, wi_q} + 6'd1) == words_q);
					out_valid_q <= 1'b1;
					ptr_q       <= ptr_q + AW'(1);
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							wi_q    <= wi_q + 5'd1;
							state_q <= S_WRD_HI;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = status_q;
	assign reg_index    = idx_q;
	assign reg_value    = value_q;
	assign last         = last_q;

endmodule
